FILE: rtl/ic_pkg.sv
// ----------------------------------------------------------------------------
// ic_pkg: shared types and constants for the inversion counter
// Token format that moves along the comparator row, plus fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ic_pkg;

  // Width of one element
  localparam int unsigned ValueW = 64;
  // Per-element count of greater predecessors; covers a row of up to 4095 cells
  localparam int unsigned CountW = 12;
  // Width of the frame total on the result side
  localparam int unsigned TotalW = 19;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};
  // Result tdata is padded to whole bytes
  localparam int unsigned OutDataW = 24;

  // One element travelling along the row
  typedef struct packed {
    logic              valid;  // token present
    logic              last;   // final element of the frame
    logic              skip;   // element past capacity: no compare, no store
    logic              done;   // element already stored in a cell
    logic              ovf;    // frame has dropped elements (meaningful on last)
    logic [CountW-1:0] count;  // stored elements seen so far that are greater
    logic [ValueW-1:0] value;  // element value, two's complement
  } tok_t;

endpackage

`default_nettype wire

FILE: rtl/ic_cell.sv
// ----------------------------------------------------------------------------
// ic_cell: one comparator cell of the row
// Holds one stored element, counts it against each passing token, stores the
// first unplaced token that finds it empty and empties on the frame's last.
// ----------------------------------------------------------------------------
`default_nettype none

module ic_cell
  import ic_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       en_i,     // row advance
  input  wire tok_t tok_i,    // token from the left neighbour
  output tok_t      tok_o     // token to the right neighbour
);

  logic              full_q, full_d;
  logic [ValueW-1:0] stored_q;
  tok_t              tok_q, tok_d;
  logic              tok_o_valid;
  logic              hit;
  logic              store;

  // Compare against the held element and decide whether to take the token
  always_comb begin
    hit   = tok_i.valid && full_q && !tok_i.skip && !tok_i.done &&
            ($signed(stored_q) > $signed(tok_i.value));
    store = tok_i.valid && !full_q && !tok_i.skip && !tok_i.done && !tok_i.last;

    full_d = full_q;
    if (tok_i.valid && tok_i.last) begin
      full_d = 1'b0;
    end else if (store) begin
      full_d = 1'b1;
    end

    tok_d       = tok_i;
    tok_d.done  = tok_i.done | store;
    tok_d.count = tok_i.count + CountW'(hit);
  end

  // Occupancy and token presence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q      <= 1'b0;
      tok_o_valid <= 1'b0;
    end else if (en_i) begin
      full_q      <= full_d;
      tok_o_valid <= tok_d.valid;
    end
  end

  // Held element and token payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (store) begin
        stored_q <= tok_i.value;
      end
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_o_valid;
  end

endmodule

`default_nettype wire

FILE: rtl/ic_tail.sv
// ----------------------------------------------------------------------------
// ic_tail: frame accumulator and result register
// Sums the per-element counts leaving the row, saturates the total and holds
// one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ic_tail
  import ic_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire tok_t           tok_i,     // token leaving the last cell
  output logic                en_o,      // row advance
  output logic                valid_o,
  input  wire                 ready_i,
  output logic [TotalW-1:0]   total_o,
  output logic                ovf_o
);

  logic [TotalW-1:0] acc_q, acc_d;
  logic [TotalW:0]   sum;
  logic [TotalW-1:0] sat;
  logic              valid_q, valid_d;
  logic [TotalW-1:0] total_q;
  logic              ovf_q;
  logic              take;

  // Stall the row only when a finished frame meets a held result
  assign en_o = !(tok_i.valid && tok_i.last && valid_q && !ready_i);
  assign take = en_o && tok_i.valid;

  // Add this element's count, clamp at the top of the range
  always_comb begin
    sum = {1'b0, acc_q} + (TotalW + 1)'(tok_i.count);
    sat = sum[TotalW] ? TotalMax : sum[TotalW-1:0];

    acc_d = acc_q;
    if (take) begin
      acc_d = tok_i.last ? '0 : sat;
    end

    valid_d = valid_q && !ready_i;
    if (take && tok_i.last) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      valid_q <= valid_d;
    end
  end

  // Load the result beat
  always_ff @(posedge clk_i) begin
    if (take && tok_i.last) begin
      total_q <= sat;
      ovf_q   <= tok_i.ovf;
    end
  end

  assign valid_o = valid_q;
  assign total_o = total_q;
  assign ovf_o   = ovf_q;

endmodule

`default_nettype wire

FILE: rtl/inversion_counter.sv
// ----------------------------------------------------------------------------
// inversion_counter: streaming strict inversion count
// Counts pairs i<j with a[i] > a[j] over each frame of signed elements using
// a row of comparator cells, one element stored per cell.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata                         tuser        tlast
//  s_axis    in         [63:0] value                  -            frame end
//  m_axis    out        [18:0] inversion_total        overflowed   -
//
//  Takes one beat per cycle while the input is not stalled. The result of
//  a frame follows its last beat through every cell of the row and the result register.
//  Reset empties every cell at once; no clearing pass is needed.
//  The input stalls only while a result is held on m_axis and the next
//  frame's last element has reached the end of the row.
//  Elements beyond MAX_ITEMS in a frame are dropped and flag the result.
// ----------------------------------------------------------------------------
`default_nettype none

module inversion_counter
  import ic_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // input stream
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire  [ValueW-1:0]    s_axis_tdata_i,   // [63:0] value
  input  wire                  s_axis_tlast_i,
  // result stream
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  output logic [OutDataW-1:0]  m_axis_tdata_o,   // [18:0] inversion_total, [23:19] zero
  output logic                 m_axis_tuser_o    // [0] overflowed
);

  localparam int unsigned FillW = $clog2(MAX_ITEMS + 1);
  localparam logic [FillW-1:0] FillFull = FillW'(MAX_ITEMS);

  logic             en;
  logic             accept;
  logic             drop;
  logic [FillW-1:0] fill_q, fill_d;
  logic             ovf_q, ovf_d;
  tok_t             head;
  tok_t             row [MAX_ITEMS+1];
  logic [TotalW-1:0] total;

  assign s_axis_tready_o = en;
  assign accept = s_axis_tvalid_i && en;
  assign drop   = (fill_q == FillFull);

  // Build the entry token; drop elements past capacity unless they close the frame
  always_comb begin
    head.valid = accept && (!drop || s_axis_tlast_i);
    head.last  = s_axis_tlast_i;
    head.skip  = drop;
    head.done  = 1'b0;
    head.ovf   = ovf_q | drop;
    head.count = '0;
    head.value = s_axis_tdata_i;

    fill_d = fill_q;
    ovf_d  = ovf_q;
    if (accept) begin
      if (s_axis_tlast_i) begin
        fill_d = '0;
        ovf_d  = 1'b0;
      end else begin
        fill_d = drop ? fill_q : fill_q + FillW'(1);
        ovf_d  = ovf_q | drop;
      end
    end
  end

  assign row[0] = head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
    end
  end

  // Comparator row
  for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
    ic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tok_i  (row[gi]),
      .tok_o  (row[gi+1])
    );
  end

  // Frame total and result beat
  ic_tail u_tail (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tok_i   (row[MAX_ITEMS]),
    .en_o    (en),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .total_o (total),
    .ovf_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(OutDataW - TotalW){1'b0}}, total};

  // Fill level never passes capacity
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("fill level above capacity");

  // Input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("row stalled without a held result");

  // A frame end leaving the row produces a result beat
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && row[MAX_ITEMS].valid && row[MAX_ITEMS].last) |=> m_axis_tvalid_o)
    else $error("frame end lost at the tail");

  // A dropped element that does not close the frame leaves the fill level alone
  a_drop_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && drop && !s_axis_tlast_i) |=> (fill_q == FillFull))
    else $error("dropped element changed the fill level");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for inversion_counter
// Streams frames of signed 64-bit elements into the block and predicts the
// strict inversion count and overflow flag of every frame. Each result beat
// is checked against the oldest prediction. Both stream sides idle at random.
// Runs include short frames and a frame that fills the row strictly
// descending, for the largest possible total, and then overruns it.
// ----------------------------------------------------------------------------
module tb
  import ic_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxItems  = 1024;
  localparam int unsigned TotalCap  = 524287;
  localparam int unsigned MaxWait   = 13;
  localparam logic [ValueW-1:0] Int64Min = 64'h8000_0000_0000_0000;
  localparam logic [ValueW-1:0] Int64Max = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValueW-1:0] AllOnes  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [ValueW-1:0] value;
    logic              fin;
    int unsigned       gap;    // idle cycles after this beat
    bit                drain;  // hold this beat until every total is back
  } beat_t;

  typedef struct packed {
    logic [TotalW-1:0] total;
    logic              ovf;
  } frame_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_tvalid = 1'b0;
  logic [ValueW-1:0]   s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                s_tready;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  // stimulus and prediction state
  beat_t                    beats_left[$];
  frame_result_t            totals_due[$];
  logic signed [ValueW-1:0] frame_vals[$];
  int unsigned              run_total     = 0;
  logic                     frame_dropped = 1'b0;
  beat_t                    next_beat;
  int unsigned              gap_left   = 0;
  int unsigned              stall_left = 0;
  int unsigned              stall_draw;
  int                       in_quiet   = 0;
  int                       out_quiet  = 0;

  int unsigned errors       = 0;
  int unsigned beats_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned frames_sent  = 0;
  int unsigned drop_frames  = 0;

  inversion_counter #(
    .MAX_ITEMS(MaxItems)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  // 100 MHz clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Draw an idle count; now and then start a run with no idling at all
  function automatic int unsigned draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) quiet = $urandom_range(10, 60);
    return $urandom_range(0, MaxWait);
  endfunction

  // Count stored elements above the new one, then store it; close the frame on last
  task automatic tally_element(input logic signed [ValueW-1:0] v, input logic fin);
    int unsigned above;
    above = 0;
    if (frame_vals.size() < MaxItems) begin
      foreach (frame_vals[k]) if (frame_vals[k] > v) above++;
      if (above > TotalCap - run_total) run_total = TotalCap;
      else run_total += above;
      frame_vals.push_back(v);
    end else begin
      frame_dropped = 1'b1;
    end
    beats_taken++;
    if (fin) begin
      totals_due.push_back('{total: run_total[TotalW-1:0], ovf: frame_dropped});
      frame_vals.delete();
      run_total     = 0;
      frame_dropped = 1'b0;
    end
  endtask

  // Compare one result beat with the oldest predicted frame total
  task automatic check_result();
    frame_result_t want;
    results_seen++;
    if (totals_due.size() == 0) begin
      $display("%0t: result with none expected: total %0d overflowed %0b", $time,
               m_tdata[TotalW-1:0], m_tuser);
      errors++;
    end else begin
      want = totals_due.pop_front();
      if (m_tdata[TotalW-1:0] !== want.total) begin
        $display("%0t: inversion_total expected %0d actual %0d", $time, want.total,
                 m_tdata[TotalW-1:0]);
        errors++;
      end
      if (m_tuser !== want.ovf) begin
        $display("%0t: overflowed expected %0b actual %0b", $time, want.ovf, m_tuser);
        errors++;
      end
    end
  endtask

  task automatic add_beat(input logic [ValueW-1:0] v, input logic fin, input bit drain);
    beats_left.push_back('{value: v, fin: fin, gap: draw_wait(in_quiet), drain: drain});
    if (fin) frames_sent++;
  endtask

  // Element content by frame flavour
  function automatic logic [ValueW-1:0] pick_value(input int unsigned flavour,
                                                   input int unsigned pos);
    logic [ValueW-1:0] v;
    case (flavour)
      0: v = {$urandom(), $urandom()};
      1: begin
        v = 64'($urandom_range(0, 8));
        v = v - 64'd4;
      end
      2: begin
        case ($urandom_range(0, 4))
          0: v = Int64Min;
          1: v = Int64Max;
          2: v = '0;
          3: v = AllOnes;
          default: v = {$urandom(), $urandom()};
        endcase
      end
      default: v = 64'd1000 - 64'(pos) * 64'd3 + 64'($urandom_range(0, 4));
    endcase
    return v;
  endfunction

  // Input side: present beats, honour gaps and the drain hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) tally_element(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          s_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (beats_left.size() != 0 &&
                     !(beats_left[0].drain && totals_due.size() != 0)) begin
          next_beat = beats_left.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= next_beat.value;
          s_tlast   <= next_beat.fin;
          gap_left  <= next_beat.gap;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: check each beat, then stall for a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (stall_left != 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (m_tvalid && m_tready) begin
        stall_draw = draw_wait(out_quiet);
        stall_left <= stall_draw;
        m_tready   <= (stall_draw == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int unsigned random_beats;
    int unsigned len;
    int unsigned flavour;
    bit          big_done;
    bit          drain;

    random_beats = 0;
    big_done     = 1'b0;

    // single element: nothing stored before the marked beat
    add_beat(Int64Min, 1'b1, 1'b0);
    // descending through both extremes and the sign boundary
    add_beat(Int64Max, 1'b0, 1'b0);
    add_beat('0, 1'b0, 1'b0);
    add_beat(AllOnes, 1'b0, 1'b0);
    add_beat(Int64Min, 1'b1, 1'b0);
    // equal values never count
    add_beat(64'd5, 1'b0, 1'b0);
    add_beat(64'd5, 1'b0, 1'b0);
    add_beat(64'd5, 1'b1, 1'b0);
    // ascending across the whole range
    add_beat(Int64Min, 1'b0, 1'b0);
    add_beat(AllOnes, 1'b0, 1'b0);
    add_beat('0, 1'b0, 1'b0);
    add_beat(64'd1, 1'b0, 1'b0);
    add_beat(Int64Max, 1'b1, 1'b0);
    // alternating signs
    add_beat(64'd1, 1'b0, 1'b0);
    add_beat(AllOnes, 1'b0, 1'b0);
    add_beat(64'd1, 1'b0, 1'b0);
    add_beat(AllOnes, 1'b1, 1'b0);
    // alternating bit patterns, positive then negative and back
    add_beat(64'h5555_5555_5555_5555, 1'b0, 1'b0);
    add_beat(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    add_beat(64'h5555_5555_5555_5555, 1'b1, 1'b0);

    // random frames, mostly short, with the capacity frame partway
    while (random_beats < 340) begin
      len     = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120)
                                            : $urandom_range(1, 24);
      flavour = $urandom_range(0, 3);
      drain   = (random_beats == 0) || ($urandom_range(0, 29) == 0);
      for (int unsigned i = 0; i < len; i++)
        add_beat(pick_value(flavour, i), i == len - 1, drain && i == 0);
      random_beats += len;

      if (!big_done && random_beats > 150) begin
        big_done = 1'b1;
        // fill the row strictly descending for the largest total, then overrun it;
        // the marked beat itself is dropped
        for (int unsigned k = 0; k < MaxItems + 2; k++)
          add_beat((k < MaxItems) ? Int64Max - 64'(k) * (64'd1 << 54)
                                  : {$urandom(), $urandom()},
                   k == MaxItems + 1, k == 0);
        drop_frames++;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // let the input queue empty, then wait for every total
    while (beats_left.size() != 0 || s_tvalid) @(posedge clk_i);
    while (totals_due.size() != 0) @(posedge clk_i);
    // catch stray results still inside the row
    repeat (2 * MaxItems + 20) @(posedge clk_i);

    if (totals_due.size() != 0) begin
      $display("%0t: %0d frame totals never arrived", $time, totals_due.size());
      errors++;
    end

    $display("Sent %0d frames (%0d beats, %0d past capacity); checked %0d totals.",
             frames_sent, beats_taken, drop_frames, results_seen);
    $display("Covered sign extremes, equal values, full-row and overrun frames.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Timed out with %0d beats and %0d totals outstanding",
             beats_left.size(), totals_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
